[rtl/hse_pkg.sv]
`default_nettype none

package hse_pkg;

  // element width and store depth
  localparam int DW    = 32;
  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = AW + 1;

  // one result handed from the sorter to the output register
  typedef struct packed {
    logic [DW-1:0] value;
    logic          last;
    logic          ovf;
  } emit_t;

endpackage

`default_nettype wire

[rtl/heap_sort_engine_unit.sv]
// channel   signals                          direction
// input     in_valid, in_stall, value, last  value/last in, in_stall out
// output    out_valid, out_stall,            sorted_value/last_out/overflow out,
//           sorted_value, last_out, overflow out_stall in
//
// a non-last element is taken when offered; the block is ready again next cycle.
// after the last element the store is built into a heap, then each root swap is followed
// by a sift-down, one level compared at a time; then the results are read out one by one.
// one store read port and one compare unit serve every step.
// reset clears the element count, the overflow flag and out_valid.
// out_stall holds the output register; emission waits only while it is full and stalled.
`default_nettype none

module heap_sort_engine_unit import hse_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [DW-1:0] value,
  input  logic          last,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [DW-1:0] sorted_value,
  output logic          last_out,
  output logic          overflow
);

  logic  ready;
  logic  in_take;
  logic  em_valid;
  logic  em_room;
  emit_t em;

  assign in_stall = !ready;
  assign in_take  = in_valid && ready;
  assign em_room  = !out_valid || !out_stall;

  hse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .in_value (value),
    .in_last  (last),
    .ready    (ready),
    .em_room  (em_room),
    .em_valid (em_valid),
    .em       (em)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (em_valid && em_room) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_valid && em_room) begin
      sorted_value <= em.value;
      last_out     <= em.last;
      overflow     <= em.ovf;
    end
  end

endmodule

`default_nettype wire

[rtl/hse_core.sv]
`default_nettype none

module hse_core import hse_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_take,
  input  logic [DW-1:0] in_value,
  input  logic          in_last,
  output logic          ready,
  input  logic          em_room,
  output logic          em_valid,
  output emit_t         em
);

  // sequencer states
  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_BLD  = 4'd1;
  localparam logic [3:0] S_SV   = 4'd2;
  localparam logic [3:0] S_SL   = 4'd3;
  localparam logic [3:0] S_SA   = 4'd4;
  localparam logic [3:0] S_SB   = 4'd5;
  localparam logic [3:0] S_CP   = 4'd6;
  localparam logic [3:0] S_DN   = 4'd7;
  localparam logic [3:0] S_W0   = 4'd8;
  localparam logic [3:0] S_W1   = 4'd9;
  localparam logic [3:0] S_W2   = 4'd10;
  localparam logic [3:0] S_ER   = 4'd11;
  localparam logic [3:0] S_EW   = 4'd12;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] n;
  logic [AW-1:0] bi;
  logic [AW-1:0] j;
  logic [AW-1:0] c;
  logic [AW:0]   l;
  logic [AW-1:0] hend;
  logic [AW-1:0] k;
  logic [AW-1:0] ci;
  logic          sorting;
  logic [DW-1:0] v;
  logic [DW-1:0] a;
  logic [DW-1:0] child;

  // store, one write and one read port, registered read data
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd;
  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;
  logic          re;
  logic [AW-1:0] ra;

  // shared compare unit
  logic [DW-1:0] cmp_x;
  logic [DW-1:0] cmp_y;
  logic          lt;

  logic [AW:0]   lc;
  logic [CW-1:0] n_new;
  logic          is_last_k;

  assign lc        = {c, 1'b1};
  assign n_new     = (count < CW'(DEPTH)) ? count + CW'(1) : count;
  assign is_last_k = ({1'b0, k} + CW'(1)) == n;

  assign ready    = (state == S_LOAD);
  assign em_valid = (state == S_EW);
  assign em.value = rd;
  assign em.last  = is_last_k;
  assign em.ovf   = ovf;

  // comparator operands: children in S_SB, parent vs child in S_CP
  always_comb begin
    if (state == S_SB) begin
      cmp_x = a;
      cmp_y = rd;
    end else begin
      cmp_x = v;
      cmp_y = child;
    end
  end
  assign lt = $signed(cmp_x) < $signed(cmp_y);

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = c;
    wd = v;
    re = 1'b0;
    ra = k;
    case (state)
      S_LOAD: begin
        we = in_take && (count < CW'(DEPTH));
        wa = count[AW-1:0];
        wd = in_value;
      end
      S_BLD: begin
        re = 1'b1;
        ra = bi - AW'(1);
      end
      S_SL: begin
        re = 1'b1;
        ra = lc[AW-1:0];
      end
      S_SA: begin
        re = 1'b1;
        ra = l[AW-1:0] + AW'(1);
      end
      S_CP: begin
        we = lt;
        wa = c;
        wd = child;
      end
      S_DN: begin
        we = 1'b1;
        wa = c;
        wd = v;
      end
      S_W0: begin
        re = 1'b1;
        ra = j;
      end
      S_W1: begin
        re = 1'b1;
        ra = '0;
      end
      S_W2: begin
        we = 1'b1;
        wa = j;
        wd = rd;
      end
      S_ER: begin
        re = 1'b1;
        ra = k;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

  // sequencer: load, heap build, root swaps with sift-down, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_take) begin
            if (count < CW'(DEPTH)) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (in_last) begin
              n <= n_new;
              k <= '0;
              bi <= n_new[CW-1:1];
              if (n_new >= CW'(2)) begin
                state <= S_BLD;
              end else begin
                state <= S_ER;
              end
            end
          end
        end
        S_BLD: begin
          c       <= bi - AW'(1);
          bi      <= bi - AW'(1);
          hend    <= AW'(n - CW'(1));
          sorting <= 1'b0;
          state   <= S_SV;
        end
        S_SV: begin
          v     <= rd;
          state <= S_SL;
        end
        S_SL: begin
          if (lc > {1'b0, hend}) begin
            state <= S_DN;
          end else begin
            l     <= lc;
            state <= S_SA;
          end
        end
        S_SA: begin
          if (l[AW-1:0] < hend) begin
            a     <= rd;
            state <= S_SB;
          end else begin
            child <= rd;
            ci    <= l[AW-1:0];
            state <= S_CP;
          end
        end
        S_SB: begin
          if (lt) begin
            child <= rd;
            ci    <= l[AW-1:0] + AW'(1);
          end else begin
            child <= a;
            ci    <= l[AW-1:0];
          end
          state <= S_CP;
        end
        S_CP: begin
          if (lt) begin
            c     <= ci;
            state <= S_SL;
          end else begin
            state <= S_DN;
          end
        end
        S_DN: begin
          if (!sorting) begin
            if (bi != '0) begin
              state <= S_BLD;
            end else begin
              j     <= AW'(n - CW'(1));
              state <= S_W0;
            end
          end else if (j == AW'(1)) begin
            k     <= '0;
            state <= S_ER;
          end else begin
            j     <= j - AW'(1);
            state <= S_W0;
          end
        end
        S_W0: begin
          state <= S_W1;
        end
        S_W1: begin
          v     <= rd;
          state <= S_W2;
        end
        S_W2: begin
          c       <= '0;
          hend    <= j - AW'(1);
          sorting <= 1'b1;
          state   <= S_SL;
        end
        S_ER: begin
          state <= S_EW;
        end
        S_EW: begin
          if (em_room) begin
            if (is_last_k) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k     <= k + AW'(1);
              state <= S_ER;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/hse_checker.sv]
`default_nettype none

module hse_checker import hse_pkg::*; (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          last,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire logic [DW-1:0] sorted_value,
  input wire logic          last_out,
  input wire logic          overflow
);

  // block comes out of reset empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // a plain element never makes the block busy
  a_plain_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last |=> !in_stall)
    else $error("busy after non-last element");

  // the closing element starts the sort, so input stalls
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("ready right after last element");

  // stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_value)
      && $stable(last_out) && $stable(overflow))
    else $error("stalled result changed");

endmodule

bind heap_sort_engine_unit hse_checker u_hse_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last         (last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sorted_value (sorted_value),
  .last_out     (last_out),
  .overflow     (overflow)
);

`default_nettype wire

[tb/heap_sort_engine_unit_tb.sv]
`timescale 1ns / 100ps

module heap_sort_engine_unit_tb;
  import hse_pkg::*;

  localparam int ITEMS       = 350;
  localparam int HOLD_CYCLES = 2000;
  localparam int TAIL_CYCLES = 200;

  // one row of the directed table; exp_val is used only where typed is set
  typedef struct packed {
    logic [DW-1:0] val;
    logic          lst;
    logic          typed;
    logic [DW-1:0] exp_val;
  } stim_row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic [DW-1:0] value;
  logic          last;
  logic          out_valid;
  logic          out_stall;
  logic [DW-1:0] sorted_value;
  logic          last_out;
  logic          overflow;

  // sorter model state
  logic [DW-1:0] held [DEPTH];
  logic [CW-1:0] held_n;
  logic          held_ovf;
  emit_t         ascending_q [$];

  int err_cnt;
  int sent;
  bit calm;
  bit hold_req;

  stim_row_t dir_rows [0:19] = '{
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
    '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'hffff_fffe, 1'b1, 1'b0, 32'h0},
    '{32'haaaa_aaaa, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h7fff_fffe, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h7fff_ffff, 1'b1, 1'b0, 32'h0}
  };

  heap_sort_engine_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // store one accepted element; on last, queue the set in ascending order
  task automatic absorb_element(input logic [DW-1:0] v, input logic l, input bit emit);
    logic [DW-1:0] srt [DEPTH];
    logic [DW-1:0] key;
    int            n;
    int            j;
    if (held_n < DEPTH) begin
      held[held_n[AW-1:0]] = v;
      held_n = held_n + 1'b1;
    end else begin
      held_ovf = 1'b1;
    end
    if (l) begin
      n = held_n;
      for (int i = 0; i < n; i++) srt[i] = held[i];
      for (int i = 1; i < n; i++) begin
        key = srt[i];
        j = i;
        while (j > 0 && $signed(srt[j-1]) > $signed(key)) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = key;
      end
      if (emit)
        for (int i = 0; i < n; i++) ascending_q.push_back('{srt[i], i == n - 1, held_ovf});
      held_n = '0;
      held_ovf = 1'b0;
    end
  endtask

  // offer one element, idling first at random, and wait for its transfer
  task automatic send_item(input logic [DW-1:0] v, input logic l, input bit emit);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    absorb_element(v, l, emit);
  endtask

  // stop offering until every queued result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ascending_q.size() != 0) @(posedge clk);
  endtask

  // random element: full range, clustered duplicates, extremes and near-extremes
  function automatic logic [DW-1:0] pick_value();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      5, 6:    return DW'($urandom_range(0, 6)) - DW'(3);
      7: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      8:       return 32'h8000_0000 + DW'($urandom_range(0, 3));
      9:       return 32'h7fff_ffff - DW'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // set size: mostly small, a few full and a few overflowing the store
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 32);
    if (r < 95) return DEPTH;
    return $urandom_range(DEPTH + 1, DEPTH + 8);
  endfunction

  task automatic send_set(input int n);
    for (int k = 0; k < n; k++) send_item(pick_value(), k == n - 1, 1'b1);
  endtask

  // stimulus
  initial begin
    int set_idx;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= '0;
    last     <= 1'b0;
    held_n   = '0;
    held_ovf = 1'b0;
    err_cnt  = 0;
    sent     = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].typed)
        ascending_q.push_back('{dir_rows[r].exp_val, 1'b1, 1'b0});
      send_item(dir_rows[r].val, dir_rows[r].lst, !dir_rows[r].typed);
    end
    drain_results();

    // store overflow with last dropped, then an exactly full store
    send_set(DEPTH + 1);
    send_set(DEPTH);

    // random sets
    set_idx = 0;
    while (sent < ITEMS) begin
      calm = (set_idx >= 6 && set_idx < 12);
      if (set_idx == 3) hold_req = 1'b1;
      if (set_idx == 10) drain_results();
      send_set(pick_size());
      set_idx++;
    end
    calm = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("heap_sort_engine_unit_tb OK");
    else
      $display("heap_sort_engine_unit_tb NOT OK");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && $urandom_range(0, 99) < 17;
      end
    end
  end

  // result check against the oldest expected entry
  always @(posedge clk) begin
    emit_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (ascending_q.size() == 0) begin
        $display("%0t: unexpected result sorted_value %h last_out %b overflow %b",
                 $time, sorted_value, last_out, overflow);
        err_cnt++;
      end else begin
        exp = ascending_q.pop_front();
        if (sorted_value !== exp.value) begin
          $display("%0t: sorted_value expected %h actual %h", $time, exp.value, sorted_value);
          err_cnt++;
        end
        if (last_out !== exp.last) begin
          $display("%0t: last_out expected %b actual %b", $time, exp.last, last_out);
          err_cnt++;
        end
        if (overflow !== exp.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, exp.ovf, overflow);
          err_cnt++;
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("heap_sort_engine_unit_tb NOT OK");
    $finish;
  end

endmodule
